// ===== sv/rcsc_pkg.sv =====
// Shared types and defaults of the read coverage site counter.
// Used by rcsc_site_mem, rcsc_seq and read_coverage_site_counter; depends on nothing.
package rcsc_pkg;

  localparam int SitesDef     = 65536;
  localparam int MaxReadDef   = 255;
  localparam int DepthBitsDef = 16;

  localparam int PosW   = 16;
  localparam int ByteW  = 8;
  localparam int AnnotW = 4 * ByteW;

  typedef enum logic [1:0] {
    KIND_GENO  = 2'd0,
    KIND_ALIGN = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_QUERY
  } state_e;

  // memory strobes from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_annot;
    logic wr_depth;
  } mem_ctl_t;

endpackage

// ===== sv/read_coverage_site_counter.sv =====
// Read coverage site counter top level: streaming ports, selector register, result register.
// Depends on rcsc_pkg, rcsc_site_mem and rcsc_seq.
//
// After reset the block runs a clearing pass over the site table, one entry a cycle, with
// s_axis_tready_o low; cfg writes are taken at any time. A genotype item is a single write.
// A query is a memory read, then a load of the output register, which waits while the
// output register stays full. An alignment is a read-modify-write of the depth memory at
// one entry a cycle over its covered positions. Genotype and alignment items on other
// chromosomes, zero-length reads and unknown kinds are dropped.
module read_coverage_site_counter #(
  parameter int Sites = rcsc_pkg::SitesDef,
  parameter int MaxRead = rcsc_pkg::MaxReadDef,
  parameter int DepthBits = rcsc_pkg::DepthBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,       // chrom_select
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // chrom[7:0], position[23:8], allele_a[31:24], allele_b[39:32],
  // region_code[47:40], ref_base[55:48], read_len[63:56]
  input  logic [63:0] s_axis_tdata_i,
  input  logic [1:0]  s_axis_tuser_i,    // kind[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_position[15:0], out_allele_a[23:16], out_allele_b[31:24],
  // out_region[39:32], out_ref[47:40], depth[63:48]
  output logic [63:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o     // marked
);

  localparam int AW = $clog2(Sites);

  logic [7:0]                  chrom_sel_q;
  logic                        out_valid_q;
  logic [63:0]                 out_data_q;
  logic                        out_mark_q;

  rcsc_pkg::mem_ctl_t          mem_ctl;
  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               wr_addr;
  logic [rcsc_pkg::AnnotW-1:0] wr_annot;
  logic [DepthBits-1:0]        wr_depth;
  logic [rcsc_pkg::AnnotW-1:0] rd_annot;
  logic [DepthBits-1:0]        rd_depth;
  logic                        out_free;
  logic                        res_load;
  logic                        res_oob;
  logic [rcsc_pkg::PosW-1:0]   res_pos;
  logic [rcsc_pkg::AnnotW-1:0] res_annot;
  logic [DepthBits+15:0]       depth_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chrom_sel_q <= '0;
    end else if (cfg_we_i) begin
      chrom_sel_q <= cfg_wdata_i;
    end
  end

  assign out_free = !out_valid_q || m_axis_tready_i;

  rcsc_seq #(
    .Sites   (Sites),
    .MaxRead (MaxRead),
    .DepthW  (DepthBits)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .kind_i      (s_axis_tuser_i),
    .chrom_i     (s_axis_tdata_i[7:0]),
    .pos_i       (s_axis_tdata_i[23:8]),
    .annot_i     (s_axis_tdata_i[55:24]),
    .len_i       (s_axis_tdata_i[63:56]),
    .chrom_sel_i (chrom_sel_q),
    .out_free_i  (out_free),
    .rd_depth_i  (rd_depth),
    .mem_ctl_o   (mem_ctl),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .wr_annot_o  (wr_annot),
    .wr_depth_o  (wr_depth),
    .res_load_o  (res_load),
    .res_oob_o   (res_oob),
    .res_pos_o   (res_pos)
  );

  rcsc_site_mem #(
    .Depth  (Sites),
    .DepthW (DepthBits)
  ) u_mem (
    .clk_i      (clk_i),
    .ctl_i      (mem_ctl),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .wr_annot_i (wr_annot),
    .wr_depth_i (wr_depth),
    .rd_annot_o (rd_annot),
    .rd_depth_o (rd_depth)
  );

  // positions past the table read as zero
  assign res_annot = res_oob ? '0 : rd_annot;
  assign depth_ext = res_oob ? '0 : {16'h0000, rd_depth};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_data_q <= {depth_ext[15:0], res_annot, res_pos};
      out_mark_q <= res_annot[7:0] != 8'h00;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_mark_q;

endmodule

// ===== sv/rcsc_site_mem.sv =====
// Site table storage: annotation bytes and depth counts, one read and one write port.
// Depends on rcsc_pkg.
module rcsc_site_mem #(
  parameter int Depth = rcsc_pkg::SitesDef,
  parameter int DepthW = rcsc_pkg::DepthBitsDef,
  localparam int AW = $clog2(Depth)
) (
  input  logic                        clk_i,
  input  rcsc_pkg::mem_ctl_t          ctl_i,
  input  logic [AW-1:0]               rd_addr_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [rcsc_pkg::AnnotW-1:0] wr_annot_i,
  input  logic [DepthW-1:0]           wr_depth_i,
  output logic [rcsc_pkg::AnnotW-1:0] rd_annot_o,
  output logic [DepthW-1:0]           rd_depth_o
);

  logic [rcsc_pkg::AnnotW-1:0] annot_mem [Depth];
  logic [DepthW-1:0]           depth_mem [Depth];
  logic [rcsc_pkg::AnnotW-1:0] rd_annot_q;
  logic [DepthW-1:0]           rd_depth_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_annot) begin
      annot_mem[wr_addr_i] <= wr_annot_i;
    end
    if (ctl_i.wr_depth) begin
      depth_mem[wr_addr_i] <= wr_depth_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_annot_q <= annot_mem[rd_addr_i];
      rd_depth_q <= depth_mem[rd_addr_i];
    end
  end

  assign rd_annot_o = rd_annot_q;
  assign rd_depth_o = rd_depth_q;

endmodule

// ===== sv/rcsc_seq.sv =====
// Sequencer: clearing pass, genotype writes, depth read-modify-write, query reads.
// Depends on rcsc_pkg; drives rcsc_site_mem.
module rcsc_seq #(
  parameter int Sites = rcsc_pkg::SitesDef,
  parameter int MaxRead = rcsc_pkg::MaxReadDef,
  parameter int DepthW = rcsc_pkg::DepthBitsDef,
  localparam int AW = $clog2(Sites)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  kind_i,
  input  logic [rcsc_pkg::ByteW-1:0]  chrom_i,
  input  logic [rcsc_pkg::PosW-1:0]   pos_i,
  input  logic [rcsc_pkg::AnnotW-1:0] annot_i,
  input  logic [rcsc_pkg::ByteW-1:0]  len_i,
  input  logic [rcsc_pkg::ByteW-1:0]  chrom_sel_i,
  input  logic                        out_free_i,
  input  logic [DepthW-1:0]           rd_depth_i,
  output rcsc_pkg::mem_ctl_t          mem_ctl_o,
  output logic [AW-1:0]               rd_addr_o,
  output logic [AW-1:0]               wr_addr_o,
  output logic [rcsc_pkg::AnnotW-1:0] wr_annot_o,
  output logic [DepthW-1:0]           wr_depth_o,
  output logic                        res_load_o,
  output logic                        res_oob_o,
  output logic [rcsc_pkg::PosW-1:0]   res_pos_o
);

  localparam int EW = (AW + 1 > rcsc_pkg::PosW + 1) ? AW + 1 : rcsc_pkg::PosW + 1;
  localparam int LW = rcsc_pkg::ByteW;

  rcsc_pkg::state_e             state_q, state_d;
  logic [AW-1:0]                addr_q, addr_d;
  logic [LW-1:0]                cnt_q, cnt_d;
  logic [rcsc_pkg::PosW-1:0]    pos_q, pos_d;
  logic                         oob_q, oob_d;

  logic                         pos_ok;
  logic                         match;
  logic [AW-1:0]                pos_a;
  logic [rcsc_pkg::PosW-1:0]    len_w;
  logic [rcsc_pkg::PosW-1:0]    lenc_w;
  logic [EW-1:0]                end_w;
  logic [EW-1:0]                end_c;
  logic [EW-1:0]                span_w;
  logic [LW-1:0]                span;

  always_comb begin
    pos_ok = {{(EW - rcsc_pkg::PosW){1'b0}}, pos_i} < EW'(Sites);
    match  = chrom_i == chrom_sel_i;
    pos_a  = AW'(pos_i);
    len_w  = {{(rcsc_pkg::PosW - LW){1'b0}}, len_i};
    lenc_w = (len_w > rcsc_pkg::PosW'(MaxRead)) ? rcsc_pkg::PosW'(MaxRead) : len_w;
    end_w  = EW'(pos_i) + EW'(lenc_w);
    // clip coverage at the table end
    end_c  = (end_w > EW'(Sites)) ? EW'(Sites) : end_w;
    span_w = end_c - EW'(pos_i);
    span   = span_w[LW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcsc_pkg::ST_CLEAR;
      addr_q  <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
      oob_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      oob_q   <= oob_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    oob_d      = oob_q;
    mem_ctl_o  = '0;
    rd_addr_o  = pos_a;
    wr_addr_o  = addr_q;
    wr_annot_o = annot_i;
    wr_depth_o = rd_depth_i;
    in_ready_o = 1'b0;
    res_load_o = 1'b0;

    case (state_q)
      rcsc_pkg::ST_CLEAR: begin
        mem_ctl_o.wr_annot = 1'b1;
        mem_ctl_o.wr_depth = 1'b1;
        wr_annot_o = '0;
        wr_depth_o = '0;
        if (addr_q == AW'(Sites - 1)) begin
          addr_d  = '0;
          state_d = rcsc_pkg::ST_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      rcsc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (kind_i)
            rcsc_pkg::KIND_GENO: begin
              if (match && pos_ok) begin
                mem_ctl_o.wr_annot = 1'b1;
                wr_addr_o = pos_a;
              end
            end
            rcsc_pkg::KIND_ALIGN: begin
              if (match && pos_ok && (span != '0)) begin
                mem_ctl_o.rd_en = 1'b1;
                addr_d  = pos_a;
                cnt_d   = span;
                state_d = rcsc_pkg::ST_RUN;
              end
            end
            rcsc_pkg::KIND_QUERY: begin
              pos_d = pos_i;
              oob_d = !pos_ok;
              mem_ctl_o.rd_en = pos_ok;
              state_d = rcsc_pkg::ST_QUERY;
            end
            default: begin
              // drop unknown kinds
            end
          endcase
        end
      end
      rcsc_pkg::ST_RUN: begin
        // write back the entry read last cycle, read the next one unless this is the last
        mem_ctl_o.wr_depth = 1'b1;
        wr_addr_o  = addr_q;
        wr_depth_o = (&rd_depth_i) ? rd_depth_i : rd_depth_i + 1'b1;
        if (cnt_q == LW'(1)) begin
          state_d = rcsc_pkg::ST_IDLE;
        end else begin
          mem_ctl_o.rd_en = 1'b1;
          rd_addr_o = addr_q + 1'b1;
          addr_d    = addr_q + 1'b1;
          cnt_d     = cnt_q - 1'b1;
        end
      end
      rcsc_pkg::ST_QUERY: begin
        if (out_free_i) begin
          res_load_o = 1'b1;
          state_d    = rcsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rcsc_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_oob_o = oob_q;
  assign res_pos_o = pos_q;

endmodule
